@@ rtl/core/suks_pkg.sv @@
// ----------------------------------------------------------------------------
// suks_pkg
// Shared types and constants for the sorted unique key set.
// ----------------------------------------------------------------------------
package suks_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_LIST   = 1'b1;

  // One read and one write request to the key store per cycle.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
  } mem_req_t;

endpackage

@@ rtl/core/suks_store.sv @@
// ----------------------------------------------------------------------------
// suks_store
// Key storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module suks_store
  import suks_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ rtl/core/sorted_unique_key_set.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_key_set
// Bounded set of distinct signed keys kept in ascending order in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low.
//   Commands: insert, remove, search, list. Insert and remove give no result;
//   search gives one result; list gives one result per stored key, ascending,
//   with out_last on the final one (an empty set gives none).
//   Results appear for one cycle under out_valid; the receiver cannot stall.
//   Every result carries the sticky overflow flag (an insert into a full set).
// Operation:
//   Commands on a non-empty set walk the RAM at one entry per cycle through
//   its single registered read port. search: a scan up to the key's sorted
//   position, then the result; insert: the scan, a shift of the entries above
//   the position up by one, then a write that places the key; remove: the
//   scan, then a shift of the entries above down by one; list: one key per
//   cycle after the first read. busy stays high until the command finishes.
// Reset: synchronous, clears the key count and the overflow flag; the RAM
//   contents are not cleared and are never read beyond the key count.
// ----------------------------------------------------------------------------
module sorted_unique_key_set
  import suks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic signed [31:0] in_key,
  output logic              out_valid,
  output logic              out_kind,
  output logic              out_found,
  output logic signed [31:0] out_value,
  output logic              out_last,
  output logic              out_overflow
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN     = 6'b000010,
    S_SHIFT_UP = 6'b000100,
    S_PLACE    = 6'b001000,
    S_SHIFT_DN = 6'b010000,
    S_LIST     = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic               iss_on_r, iss_on_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;

  logic               ov_r, ov_nxt;
  logic               okind_r, okind_nxt;
  logic               ofound_r, ofound_nxt;
  logic signed [31:0] ovalue_r, ovalue_nxt;
  logic               olast_r, olast_nxt;
  logic               oovf_r, oovf_nxt;

  mem_req_t           mreq;
  logic [KEY_W-1:0]   rdata;

  logic [CNT_W-1:0]   last_idx;
  logic               iss_last;
  logic               scan_hit;
  logic               issue;
  logic [CNT_W-1:0]   scan_pos;
  logic               scan_found;

  suks_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign last_idx   = cnt_r - CNT_W'(1);
  assign scan_hit   = rd_vld_r && !($signed(rdata) < key_r);
  assign scan_pos   = scan_hit ? rd_idx_r : cnt_r;
  assign scan_found = scan_hit && ($signed(rdata) == key_r);
  // Once the scan has hit its position, no further reads are issued.
  assign issue      = iss_on_r && !((state_r == S_SCAN) && scan_hit);

  always_comb begin
    unique case (state_r)
      S_SCAN, S_SHIFT_DN, S_LIST: iss_last = (ptr_r == last_idx);
      S_SHIFT_UP:                 iss_last = (ptr_r == pos_r);
      default:                    iss_last = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    iss_on_nxt = iss_on_r;
    rd_vld_nxt = issue;
    rd_idx_nxt = ptr_r;
    ov_nxt     = 1'b0;
    okind_nxt  = okind_r;
    ofound_nxt = ofound_r;
    ovalue_nxt = ovalue_r;
    olast_nxt  = olast_r;
    oovf_nxt   = ovf_r;
    mreq       = '0;

    if (issue) begin
      mreq.re    = 1'b1;
      mreq.raddr = ptr_r[ADDR_W-1:0];
      if (iss_last) begin
        iss_on_nxt = 1'b0;
      end else if (state_r == S_SHIFT_UP) begin
        ptr_nxt = ptr_r - CNT_W'(1);
      end else begin
        ptr_nxt = ptr_r + CNT_W'(1);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_t'(in_command);
          key_nxt = in_key;
          if (cmd_t'(in_command) == CMD_LIST) begin
            if (cnt_r != '0) begin
              state_nxt  = S_LIST;
              ptr_nxt    = '0;
              iss_on_nxt = 1'b1;
            end
          end else if (cnt_r == '0) begin
            // empty set: no scan needed
            if (cmd_t'(in_command) == CMD_INSERT) begin
              mreq.we    = 1'b1;
              mreq.waddr = '0;
              mreq.wdata = in_key;
              cnt_nxt    = CNT_W'(1);
            end else if (cmd_t'(in_command) == CMD_SEARCH) begin
              ov_nxt     = 1'b1;
              okind_nxt  = KIND_SEARCH;
              ofound_nxt = 1'b0;
              ovalue_nxt = '0;
              olast_nxt  = 1'b1;
            end
          end else begin
            state_nxt  = S_SCAN;
            ptr_nxt    = '0;
            iss_on_nxt = 1'b1;
          end
        end
      end

      S_SCAN: begin
        if (rd_vld_r && (scan_hit || (rd_idx_r == last_idx))) begin
          state_nxt  = S_IDLE;
          iss_on_nxt = 1'b0;
          case (cmd_r)
            CMD_SEARCH: begin
              ov_nxt     = 1'b1;
              okind_nxt  = KIND_SEARCH;
              ofound_nxt = scan_found;
              ovalue_nxt = '0;
              olast_nxt  = 1'b1;
            end
            CMD_INSERT: begin
              if (scan_found) begin
                // duplicate: set unchanged
              end else if (cnt_r == CNT_W'(CAPACITY)) begin
                ovf_nxt = 1'b1;
              end else if (scan_pos == cnt_r) begin
                mreq.we    = 1'b1;
                mreq.waddr = scan_pos[ADDR_W-1:0];
                mreq.wdata = key_r;
                cnt_nxt    = cnt_r + CNT_W'(1);
              end else begin
                state_nxt  = S_SHIFT_UP;
                pos_nxt    = scan_pos;
                ptr_nxt    = last_idx;
                iss_on_nxt = 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (!scan_found) begin
                // absent: nothing to do
              end else if (scan_pos == last_idx) begin
                cnt_nxt = last_idx;
              end else begin
                state_nxt  = S_SHIFT_DN;
                ptr_nxt    = scan_pos + CNT_W'(1);
                iss_on_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_SHIFT_UP: begin
        if (rd_vld_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = ADDR_W'(rd_idx_r + CNT_W'(1));
          mreq.wdata = rdata;
          if (rd_idx_r == pos_r) begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        mreq.we    = 1'b1;
        mreq.waddr = pos_r[ADDR_W-1:0];
        mreq.wdata = key_r;
        cnt_nxt    = cnt_r + CNT_W'(1);
        state_nxt  = S_IDLE;
      end

      S_SHIFT_DN: begin
        if (rd_vld_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = ADDR_W'(rd_idx_r - CNT_W'(1));
          mreq.wdata = rdata;
          if (rd_idx_r == last_idx) begin
            cnt_nxt   = last_idx;
            state_nxt = S_IDLE;
          end
        end
      end

      S_LIST: begin
        if (rd_vld_r) begin
          ov_nxt     = 1'b1;
          okind_nxt  = KIND_LIST;
          ofound_nxt = 1'b0;
          ovalue_nxt = rdata;
          olast_nxt  = (rd_idx_r == last_idx);
          if (rd_idx_r == last_idx) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      iss_on_r <= 1'b0;
      rd_vld_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      iss_on_r <= iss_on_nxt;
      rd_vld_r <= rd_vld_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    ptr_r    <= ptr_nxt;
    pos_r    <= pos_nxt;
    rd_idx_r <= rd_idx_nxt;
    okind_r  <= okind_nxt;
    ofound_r <= ofound_nxt;
    ovalue_r <= ovalue_nxt;
    olast_r  <= olast_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = ov_r;
  assign out_kind     = okind_r;
  assign out_found    = ofound_r;
  assign out_value    = ovalue_r;
  assign out_last     = olast_r;
  assign out_overflow = oovf_r;

  // no read may still be in flight once the block is idle
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !rd_vld_r)
    else $error("read data pending while idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

  a_search_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (okind_r == KIND_SEARCH)) |-> olast_r)
    else $error("search answer without last");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mreq.we && mreq.re) |-> (mreq.waddr != mreq.raddr))
    else $error("read and write to the same entry");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

endmodule

@@ bench/tb_sorted_unique_key_set.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_unique_key_set
// Self-checking bench for the sorted unique key set. Commands are queued up
// front and driven in random bursts. Each accepted transaction updates a
// shadow copy of the set, which queues the search answers and listed keys
// the block must return. The monitor checks every result against them.
// ----------------------------------------------------------------------------
module tb_sorted_unique_key_set;
  import suks_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 20;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] key;
    bit                 drain_first;  // wait for all answers before sending
  } set_op_t;

  typedef struct {
    logic               kind;
    logic               found;
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_command = CMD_INSERT;
  logic signed [31:0] in_key = '0;
  logic               out_valid;
  logic               out_kind;
  logic               out_found;
  logic signed [31:0] out_value;
  logic               out_last;
  logic               out_overflow;

  logic               taken = 1'b0;
  wire                op_accepted = start && !busy;

  set_op_t            ops_todo[$];
  answer_t            answers_due[$];
  logic signed [31:0] key_pool[$];

  // shadow copy of the set
  logic signed [31:0] shadow_keys[CAPACITY];
  int                 shadow_count = 0;
  logic               shadow_ovf = 1'b0;

  int                 errors = 0;
  int                 quiet_cycles = 0;
  int                 burst_left = 8;
  int                 gap_left = 0;

  sorted_unique_key_set DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_found    (out_found),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns: MISMATCH %s", $time, what);
    errors++;
  endtask

  // Apply one command to the shadow set and queue the answers it produces.
  task automatic update_key_set(input cmd_t cmd, input logic signed [31:0] key);
    int      pos;
    bit      hit;
    answer_t a;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < key) pos++;
    hit = (pos < shadow_count) && (shadow_keys[pos] == key);
    case (cmd)
      CMD_INSERT: begin
        if (!hit) begin
          if (shadow_count == CAPACITY) begin
            shadow_ovf = 1'b1;
          end else begin
            for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[pos] = key;
            shadow_count++;
          end
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
        end
      end
      CMD_SEARCH: begin
        a = '{kind: KIND_SEARCH, found: hit, value: '0, last: 1'b1, ovf: shadow_ovf};
        answers_due.push_back(a);
      end
      default: begin
        for (int i = 0; i < shadow_count; i++) begin
          a = '{kind: KIND_LIST, found: 1'b0, value: shadow_keys[i],
                last: (i + 1 == shadow_count), ovf: shadow_ovf};
          answers_due.push_back(a);
        end
      end
    endcase
  endtask

  task automatic queue_op(input cmd_t cmd, input logic signed [31:0] key, input bit drain);
    set_op_t op;
    op = '{cmd: cmd, key: key, drain_first: drain};
    ops_todo.push_back(op);
  endtask

  function automatic bit in_pool(input logic signed [31:0] k);
    foreach (key_pool[j]) if (key_pool[j] == k) return 1'b1;
    return 1'b0;
  endfunction

  // Mostly pool keys so that hits and duplicates are common.
  function automatic logic signed [31:0] pick_key(input bit pool_only);
    if (pool_only || $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom;
  endfunction

  task automatic queue_random_ops(input int n, input bit pool_inserts);
    int   roll;
    cmd_t cmd;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)      cmd = CMD_INSERT;
      else if (roll < 55) cmd = CMD_REMOVE;
      else if (roll < 85) cmd = CMD_SEARCH;
      else                cmd = CMD_LIST;
      queue_op(cmd, pick_key(pool_inserts && cmd == CMD_INSERT),
               $urandom_range(0, 19) == 0);
    end
  endtask

  // Result check, then prediction for a transaction taken on this edge.
  always @(posedge clk) begin
    answer_t a;
    if (rst_n) begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind=%0b value=%0d", out_kind, out_value));
        end else begin
          a = answers_due.pop_front();
          if (out_kind !== a.kind)
            flag_mismatch($sformatf("kind %0b, want %0b", out_kind, a.kind));
          if (out_found !== a.found)
            flag_mismatch($sformatf("found %0b, want %0b", out_found, a.found));
          if (out_value !== a.value)
            flag_mismatch($sformatf("value %0d, want %0d", out_value, a.value));
          if (out_last !== a.last)
            flag_mismatch($sformatf("last %0b, want %0b", out_last, a.last));
          if (out_overflow !== a.ovf)
            flag_mismatch($sformatf("overflow %0b, want %0b", out_overflow, a.ovf));
        end
      end
      if (op_accepted) update_key_set(cmd_t'(in_command), in_key);
      taken <= op_accepted;
    end
  end

  // Driver: bursts of commands with random gaps; noise on the idle bus.
  always @(negedge clk) begin
    set_op_t op;
    if (rst_n && (!start || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start  <= 1'b0;
        in_key <= $urandom;
      end else if (ops_todo.size() != 0 &&
                   !(ops_todo[0].drain_first && answers_due.size() != 0)) begin
        op = ops_todo.pop_front();
        start      <= 1'b1;
        in_command <= op.cmd;
        in_key     <= op.key;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 6);
        end
      end else begin
        start  <= 1'b0;
        in_key <= $urandom;
      end
    end
  end

  // Watchdog: cycles with neither a command nor a result taken.
  always @(posedge clk) begin
    if (!rst_n || op_accepted || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sorted_unique_key_set regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [31:0] k;
    int                 idx;
    int                 j;
    logic signed [31:0] fill_keys[$];

    // distinct key pool, extremes included; pool size equals capacity
    key_pool = '{KEY_MIN, KEY_MAX, 32'sd0, -32'sd1, 32'sd1, -32'sd2, 32'sd2};
    while (key_pool.size() < CAPACITY) begin
      k = ($urandom_range(0, 1) == 0) ? $urandom : int'($urandom_range(0, 200)) - 100;
      if (!in_pool(k)) key_pool.push_back(k);
    end

    // directed: empty set, extremes, duplicate, absent remove and search
    queue_op(CMD_LIST,   32'sd0,  1'b0);
    queue_op(CMD_SEARCH, 32'sd0,  1'b0);
    queue_op(CMD_REMOVE, 32'sd7,  1'b0);
    queue_op(CMD_INSERT, KEY_MAX, 1'b0);
    queue_op(CMD_INSERT, KEY_MIN, 1'b0);
    queue_op(CMD_INSERT, 32'sd0,  1'b0);
    queue_op(CMD_INSERT, -32'sd1, 1'b0);
    queue_op(CMD_INSERT, 32'sd1,  1'b0);
    queue_op(CMD_INSERT, 32'sd0,  1'b0);
    queue_op(CMD_SEARCH, KEY_MIN, 1'b0);
    queue_op(CMD_SEARCH, KEY_MAX, 1'b0);
    queue_op(CMD_SEARCH, 32'sd5,  1'b0);
    queue_op(CMD_LIST,   KEY_MAX, 1'b0);
    queue_op(CMD_REMOVE, -32'sd1, 1'b0);
    queue_op(CMD_REMOVE, 32'sd12345, 1'b0);
    queue_op(CMD_REMOVE, KEY_MIN, 1'b0);
    queue_op(CMD_LIST,   32'sd0,  1'b1);
    queue_op(CMD_SEARCH, -32'sd1, 1'b0);

    // random traffic; inserts stay in the pool so the set never overflows here
    queue_random_ops(70, 1'b1);

    // fill: insert every pool key in shuffled order, leaving the set full
    fill_keys = key_pool;
    for (int i = fill_keys.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      k = fill_keys[i];
      fill_keys[i] = fill_keys[j];
      fill_keys[j] = k;
    end
    foreach (fill_keys[i]) queue_op(CMD_INSERT, fill_keys[i], 1'b0);

    // duplicate into a full set must not flag overflow
    idx = $urandom_range(0, CAPACITY - 1);
    queue_op(CMD_INSERT, key_pool[idx], 1'b0);
    queue_op(CMD_SEARCH, key_pool[idx], 1'b0);
    queue_op(CMD_LIST,   32'sd0, 1'b1);
    do k = $urandom; while (in_pool(k));
    queue_op(CMD_INSERT, k, 1'b0);
    queue_op(CMD_SEARCH, k, 1'b0);
    queue_op(CMD_LIST,   k, 1'b0);

    queue_random_ops(72, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (ops_todo.size() != 0 || start || answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && answers_due.size() == 0) begin
      $display("sorted_unique_key_set regression: pass");
    end else begin
      $display("sorted_unique_key_set regression: fail");
    end
    $finish;
  end

endmodule
